// ===== src/dp2fx_pkg.sv =====
// Shared constants and helpers for the decimal price to fixed-point converter.
// No dependencies; imported by decimal_price_to_fixed_point_top.
package dp2fx_pkg;

	// Number of fraction digits kept in the result (result is in thousandths).
	localparam int FRAC_DIGITS = 3;
	localparam int FC_W        = $clog2(FRAC_DIGITS + 1);
	localparam int VALUE_W     = 32;

	// ASCII codes recognised by the parser.
	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_MINUS = 8'h2d;
	localparam logic [7:0] CHR_POINT = 8'h2e;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;

	// Power of ten for padding unfilled fraction positions, modulo 2^32.
	function automatic logic [VALUE_W-1:0] pow10(input logic [FC_W-1:0] n);
		logic [VALUE_W-1:0] r;
		r = VALUE_W'(1);
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			if (FC_W'(i) < n) begin
				r = VALUE_W'(r * VALUE_W'(10));
			end
		end
		return r;
	endfunction

endpackage

// ===== src/decimal_price_to_fixed_point_top.sv =====
// Streaming ASCII decimal field to fixed-point (thousandths) converter.
// Depends on dp2fx_pkg for constants and the power-of-ten function.
//
//  Channel | Direction | Signals                          | Transaction
//  --------+-----------+----------------------------------+------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tlast| one character of a field
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser| one parsed value per field
//  cfg_    | in        | cfg_valid cfg_ready cfg_data     | write of the signed_mode bit
//
// One character is taken every cycle unless the output stalls. A character passes
// an input register, then updates the parser state (one multiply-by-ten-and-add).
// On the final character the field is snapshot, then scaled in the result register
// by a power of ten set by the fraction count when a point was seen, and negated
// when a minus was seen. Reset clears all control state and the mode bit. A
// stalled output fills the two later stages, and s_tready then falls once a final
// character waits in the input register.
module decimal_price_to_fixed_point_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] character
	input  logic                           s_tlast,   // last_char
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dp2fx_pkg::VALUE_W-1:0]  m_tdata,   // [31:0] value
	output logic [0:0]                     m_tuser,   // [0] had_point
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data   // signed_mode
);
	import dp2fx_pkg::*;

	typedef enum logic [1:0] {
		PH_SKIP = 2'd0,
		PH_INT  = 2'd1,
		PH_FRAC = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	// Snapshot of a completed field, handed to the scaling stage.
	typedef struct packed {
		logic [VALUE_W-1:0] acc;
		logic [FC_W-1:0]    fc;
		logic               point;
		logic               minus;
	} field_t;

	logic                signed_mode_q;
	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                last_s1;
	phase_t              phase_q;
	logic [VALUE_W-1:0]  acc_q;
	logic [FC_W-1:0]     fc_q;
	logic                point_q;
	logic                minus_q;
	logic                valid_s2;
	field_t              field_s2;
	logic                valid_q;
	logic [VALUE_W-1:0]  value_q;
	logic                had_point_q;

	logic                out_free;
	logic                s2_free;
	logic                consume;
	phase_t              phase_d;
	logic [VALUE_W-1:0]  acc_d;
	logic [FC_W-1:0]     fc_d;
	logic                point_d;
	logic                minus_d;
	logic [VALUE_W-1:0]  prod;

	// Handshake chain: each stage moves when the one after it has room.
	assign out_free  = !valid_q || m_tready;
	assign s2_free   = !valid_s2 || out_free;
	assign consume   = valid_s1 && (!last_s1 || s2_free);
	assign s_tready  = !valid_s1 || consume;
	assign cfg_ready = 1'b1;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			signed_mode_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Parser next state for the character in the input register.
	always_comb begin
		logic       is_digit;
		logic [3:0] digit;
		logic       do_int;
		logic [VALUE_W-1:0] acc_x10;
		phase_d  = phase_q;
		acc_d    = acc_q;
		fc_d     = fc_q;
		point_d  = point_q;
		minus_d  = minus_q;
		is_digit = (char_s1 >= CHR_ZERO) && (char_s1 <= CHR_NINE);
		digit    = 4'(char_s1 - CHR_ZERO);
		acc_x10  = (acc_q << 3) + (acc_q << 1);
		do_int   = (phase_q == PH_INT) || (phase_q == PH_SKIP && char_s1 != CHR_SPACE);

		if (do_int) begin
			phase_d = PH_INT;
			if (char_s1 == CHR_NUL || char_s1 == CHR_SPACE) begin
				phase_d = PH_DONE;
			end else if (signed_mode_q && char_s1 == CHR_MINUS) begin
				minus_d = 1'b1;
			end else if (char_s1 == CHR_POINT) begin
				point_d = 1'b1;
				fc_d    = '0;
				phase_d = PH_FRAC;
			end else if (is_digit) begin
				acc_d = acc_x10 + VALUE_W'(digit);
			end
		end else if (phase_q == PH_FRAC) begin
			if (char_s1 == CHR_SPACE) begin
				phase_d = PH_DONE;
			end else begin
				if (is_digit) begin
					acc_d = acc_x10 + VALUE_W'(digit);
					fc_d  = fc_q + FC_W'(1);
				end else if (signed_mode_q) begin
					fc_d = fc_q + FC_W'(1);
				end
				if (fc_d >= FC_W'(FRAC_DIGITS)) begin
					phase_d = PH_DONE;
				end
			end
		end
	end

	// Parser state; cleared after the final character of each field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			acc_q   <= '0;
			fc_q    <= '0;
			point_q <= 1'b0;
			minus_q <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				phase_q <= PH_SKIP;
				acc_q   <= '0;
				fc_q    <= '0;
				point_q <= 1'b0;
				minus_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				fc_q    <= fc_d;
				point_q <= point_d;
				minus_q <= minus_d;
			end
		end
	end

	// Field snapshot stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= consume && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && consume && last_s1) begin
			field_s2 <= '{acc: acc_d, fc: fc_d, point: point_d, minus: minus_d};
		end
	end

	// Scale to thousandths when a point was seen, then apply the sign.
	assign prod = field_s2.point
		? VALUE_W'(field_s2.acc * pow10(FC_W'(FRAC_DIGITS) - field_s2.fc))
		: field_s2.acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			value_q     <= field_s2.minus ? VALUE_W'(0) - prod : prod;
			had_point_q <= field_s2.point;
		end
	end

	assign m_tvalid   = valid_q;
	assign m_tdata    = value_q;
	assign m_tuser[0] = had_point_q;

	// A field's last character leaves the parser in its cleared state.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_s1 |=> phase_q == PH_SKIP && acc_q == '0 && !point_q && !minus_q)
		else $error("parser not cleared after last character");

	// The fraction counter never passes the number of fraction digits.
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FC_W'(FRAC_DIGITS))
		else $error("fraction count out of range");

	// Fraction phase and fraction count imply that a point was seen.
	a_frac_point: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FRAC || fc_q != '0) |-> point_q)
		else $error("fraction state without a point");

	// A waiting snapshot is not lost while the result register is held.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(field_s2))
		else $error("field snapshot lost under stall");

endmodule

// ===== sim/decimal_price_checker.sv =====
`timescale 1ns / 1ps
// Checker for decimal_price_to_fixed_point_top: watches the character, result and mode
// channels, predicts every parsed price and compares it with the block's output.
// Depends on dp2fx_pkg for the character codes and the number of fraction digits.
module decimal_price_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] character
	input  logic                          s_tlast,   // last_char
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [dp2fx_pkg::VALUE_W-1:0] m_tdata,   // [31:0] value
	input  logic [0:0]                    m_tuser,   // [0] had_point
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          cfg_data,  // signed_mode
	output int                            failures,
	output int                            pending
);
	import dp2fx_pkg::*;

	typedef enum logic [1:0] {
		SKIP_SPACES,
		INT_PART,
		FRAC_PART,
		FIELD_DONE
	} parse_phase_e;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               had_point;
	} price_t;

	// Local copy of the parser state and of the mode register.
	logic               signed_mode;
	parse_phase_e       parse_phase;
	logic [VALUE_W-1:0] accumulator;
	logic [FC_W-1:0]    fraction_count;
	logic               point_seen;
	logic               minus_seen;

	price_t expected_prices[$];
	price_t oldest_price;

	initial begin
		failures = 0;
		pending  = 0;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		$display("%0t ns: %s mismatch: got 0x%08h, expected 0x%08h", $time, what, got, want);
		failures++;
	endtask

	function automatic logic is_digit(input logic [7:0] ch);
		return ch >= CHR_ZERO && ch <= CHR_NINE;
	endfunction

	task automatic clear_field();
		parse_phase    = SKIP_SPACES;
		accumulator    = '0;
		fraction_count = '0;
		point_seen     = 1'b0;
		minus_seen     = 1'b0;
	endtask

	function automatic logic [VALUE_W-1:0] add_digit(input logic [7:0] ch);
		return accumulator * VALUE_W'(10) + VALUE_W'(ch - CHR_ZERO);
	endfunction

	// A character of the integer part; a space or a NUL ends the field early.
	task automatic take_integer_char(input logic [7:0] ch);
		if (ch == CHR_NUL || ch == CHR_SPACE) begin
			parse_phase = FIELD_DONE;
		end else if (signed_mode && ch == CHR_MINUS) begin
			minus_seen = 1'b1;
		end else if (ch == CHR_POINT) begin
			point_seen     = 1'b1;
			fraction_count = '0;
			parse_phase    = FRAC_PART;
		end else if (is_digit(ch)) begin
			accumulator = add_digit(ch);
		end
	endtask

	// A character of the fraction; in signed mode non-digits also use up a position.
	task automatic take_fraction_char(input logic [7:0] ch);
		if (ch == CHR_SPACE) begin
			parse_phase = FIELD_DONE;
		end else begin
			if (is_digit(ch)) begin
				accumulator    = add_digit(ch);
				fraction_count = fraction_count + FC_W'(1);
			end else if (signed_mode) begin
				fraction_count = fraction_count + FC_W'(1);
			end
			if (fraction_count >= FC_W'(FRAC_DIGITS)) begin
				parse_phase = FIELD_DONE;
			end
		end
	endtask

	// Advances the parser by one character and queues the price at the end of a field.
	task automatic parse_character(input logic [7:0] ch, input logic last_char);
		price_t price;
		case (parse_phase)
			SKIP_SPACES: begin
				if (ch != CHR_SPACE) begin
					parse_phase = INT_PART;
					take_integer_char(ch);
				end
			end
			INT_PART: begin
				take_integer_char(ch);
			end
			FRAC_PART: begin
				take_fraction_char(ch);
			end
			default: begin
			end
		endcase
		if (last_char) begin
			price.value     = accumulator;
			price.had_point = point_seen;
			// Each unfilled fraction position is one factor of ten.
			if (point_seen) begin
				for (int n = fraction_count; n < FRAC_DIGITS; n++) begin
					price.value = price.value * VALUE_W'(10);
				end
			end
			if (minus_seen) begin
				price.value = VALUE_W'(0) - price.value;
			end
			expected_prices.push_back(price);
			clear_field();
		end
	endtask

	// Results are compared before the character of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode = 1'b0;
			clear_field();
			expected_prices.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				signed_mode = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				if (expected_prices.size() == 0) begin
					report_mismatch("unexpected result, value", m_tdata, '0);
				end else begin
					oldest_price = expected_prices.pop_front();
					if (m_tdata !== oldest_price.value) begin
						report_mismatch("value", m_tdata, oldest_price.value);
					end
					if (m_tuser[0] !== oldest_price.had_point) begin
						report_mismatch("had_point", VALUE_W'(m_tuser),
							VALUE_W'(oldest_price.had_point));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				parse_character(s_tdata, s_tlast);
			end
			pending = expected_prices.size();
		end
	end

endmodule

// ===== sim/decimal_price_to_fixed_point_top_test.sv =====
`timescale 1ns / 1ps
// Testbench for decimal_price_to_fixed_point_top: feeds directed and random text fields,
// toggles the signed mode between phases and leaves the checking to decimal_price_checker.
// Depends on dp2fx_pkg, decimal_price_to_fixed_point_top and decimal_price_checker.
module decimal_price_to_fixed_point_top_test;
	import dp2fx_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int GAP_MAX      = 14;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_CHARS  = 490;
	localparam int RUN_PHASES   = 4;
	localparam int STALL_LIMIT  = 2000;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // [7:0] character
	logic               s_tlast;   // last_char
	logic               m_tvalid;
	logic               m_tready;
	logic [VALUE_W-1:0] m_tdata;   // [31:0] value
	logic [0:0]         m_tuser;   // [0] had_point
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_data;  // signed_mode

	logic [7:0] field_q[$];
	bit         idle_on;
	bit         stalls_on;
	bit         hold_off;
	int         failures;
	int         pending;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	decimal_price_to_fixed_point_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	decimal_price_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	// Watchdog: ends the run after too many cycles without any transaction.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("decimal_price_to_fixed_point_top_test NOT OK");
		$finish;
	end

	// Result receiver: random stall bursts, and a long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
				m_tready <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic add_text(input string text);
		for (int i = 0; i < text.len(); i++) begin
			field_q.push_back(text[i]);
		end
	endtask

	// Sends the queued field one character per transaction, last flag on the final one.
	task automatic send_field();
		for (int i = 0; i < field_q.size(); i++) begin
			if (idle_on && $urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= field_q[i];
			s_tlast  <= (i == field_q.size() - 1);
			do @(posedge clk); while (!s_tready);
		end
		field_q.delete();
	endtask

	// Stops sending, waits for every expected price and lets the pipeline run dry.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_signed_mode(input logic mode);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int chars_sent;
		int n_digits;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		idle_on   = 1'b0;
		stalls_on = 1'b0;
		hold_off  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed fields in unsigned mode: leading space, point as last character,
		// lone NUL, lone top byte, space ending the integer part, ignored minus.
		write_signed_mode(1'b0);
		add_text(" 1.5");
		send_field();
		add_text("9.");
		send_field();
		field_q.push_back(CHR_NUL);
		send_field();
		field_q.push_back(8'hff);
		send_field();
		add_text("3 7");
		send_field();
		add_text("-8");
		send_field();

		// Directed fields in signed mode: non-digits filling the fraction, NUL inside
		// the fraction, repeated minus signs.
		settle();
		write_signed_mode(1'b1);
		add_text("-2.5x9");
		send_field();
		add_text("4.");
		field_q.push_back(CHR_NUL);
		add_text("1");
		send_field();
		add_text("--6");
		send_field();

		// Random phases with alternating mode; the last phase runs without idling.
		for (int phase_no = 0; phase_no < RUN_PHASES; phase_no++) begin
			settle();
			write_signed_mode(phase_no % 2 == 1);
			if (phase_no == 1 || phase_no == 2) begin
				hold_off <= 1'b1;
			end
			chars_sent = 0;
			while (chars_sent < PHASE_CHARS) begin
				if ($urandom_range(0, 9) < 8) begin
					// Well-formed price with random content, sometimes overflowing.
					repeat ($urandom_range(0, 3)) field_q.push_back(CHR_SPACE);
					if ($urandom_range(0, 2) == 0) begin
						field_q.push_back(CHR_MINUS);
					end
					n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) :
						$urandom_range(0, 6);
					repeat (n_digits) field_q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
					if ($urandom_range(0, 3) != 0) begin
						field_q.push_back(CHR_POINT);
						repeat ($urandom_range(0, 5)) begin
							if ($urandom_range(0, 7) == 0) begin
								field_q.push_back(8'($urandom_range(0, 255)));
							end else begin
								field_q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
							end
						end
					end
					if ($urandom_range(0, 3) == 0) begin
						field_q.push_back(CHR_SPACE);
						repeat ($urandom_range(0, 3)) field_q.push_back(8'($urandom_range(0, 255)));
					end
					if (field_q.size() == 0) begin
						field_q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
					end
				end else begin
					// Noise: random bytes mixed with the characters the parser reacts to.
					repeat ($urandom_range(1, 8)) begin
						case ($urandom_range(0, 5))
							0: field_q.push_back(CHR_SPACE);
							1: field_q.push_back(CHR_NUL);
							2: field_q.push_back(CHR_POINT);
							3: field_q.push_back(CHR_MINUS);
							4: field_q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
							default: field_q.push_back(8'($urandom_range(0, 255)));
						endcase
					end
				end
				idle_on   = (phase_no != RUN_PHASES - 1) && $urandom_range(0, 3) != 0;
				stalls_on = (phase_no != RUN_PHASES - 1) && $urandom_range(0, 3) != 0;
				chars_sent += field_q.size();
				send_field();
			end
		end

		settle();
		if (failures == 0 && pending == 0) begin
			$display("decimal_price_to_fixed_point_top_test OK");
		end else begin
			$display("decimal_price_to_fixed_point_top_test NOT OK");
		end
		$finish;
	end

endmodule
